// ===== rtl/core/mmn_pkg.sv =====
// Shared definitions for the magnetometer median normalizer.
// Field widths, register indexes, reset values and the scaler result type.
// No dependencies.
package mmn_pkg;

    // Field widths.
    localparam int RAW_W      = 16;
    localparam int CEN_W      = 20;
    localparam int GAIN_W     = 25;
    localparam int NORM_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Default window length.
    localparam int MMN_WINDOW_LEN = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GAIN = 2'd2;

    // Configuration reset values.
    localparam logic [CEN_W-1:0]  CENTER_X_RST   = 20'd4072;
    localparam logic [CEN_W-1:0]  CENTER_Y_RST   = 20'd1232;
    localparam logic [GAIN_W-1:0] RANGE_GAIN_RST = 25'd36511;

    // One normalized axis and its saturation flag.
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic              clip;
    } t_scale_res;

endpackage

// ===== rtl/core/mmn_rank.sv =====
// Rank test for one window candidate: a bank of comparators against every tap.
// Depends on mmn_pkg for the sample width.
module mmn_rank #(
    parameter int WINDOW_LEN = mmn_pkg::MMN_WINDOW_LEN
) (
    input  logic [WINDOW_LEN-1:0][mmn_pkg::RAW_W-1:0] i_win,
    input  logic [$clog2(WINDOW_LEN)-1:0]             i_idx,
    output logic [mmn_pkg::RAW_W-1:0]                 o_cand,
    output logic                                      o_hit
);
    import mmn_pkg::*;

    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int MED_IDX = WINDOW_LEN / 2;

    logic [WINDOW_LEN-1:0] lt_vec;
    logic [WINDOW_LEN-1:0] le_vec;
    logic [CNT_W-1:0]      n_lt;
    logic [CNT_W-1:0]      n_le;

    // Compare the candidate against every tap in parallel.
    always_comb begin
        o_cand = i_win[i_idx];
        for (int j = 0; j < WINDOW_LEN; j++) begin
            lt_vec[j] = $signed(i_win[j]) <  $signed(o_cand);
            le_vec[j] = $signed(i_win[j]) <= $signed(o_cand);
        end
        n_lt = CNT_W'($countones(lt_vec));
        n_le = CNT_W'($countones(le_vec));
    end

    // The candidate sits at the middle sorted position when fewer than or
    // exactly MED_IDX taps lie below it and more than MED_IDX lie at or below.
    assign o_hit = (n_lt <= CNT_W'(MED_IDX)) && (n_le > CNT_W'(MED_IDX));

endmodule

// ===== rtl/core/mmn_scale.sv =====
// Shared scaler: center removal, multiply by the range gain, round and saturate.
// Depends on mmn_pkg for widths and the result type.
module mmn_scale (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [mmn_pkg::RAW_W-1:0]     i_med,
    input  logic [mmn_pkg::CEN_W-1:0]     i_center,
    input  logic [mmn_pkg::GAIN_W-1:0]    i_gain,
    output mmn_pkg::t_scale_res           o_res
);
    import mmn_pkg::*;

    localparam int D_W    = RAW_W + 6;
    localparam int PROD_W = D_W + GAIN_W + 1;
    localparam int FRAC   = 14;
    localparam int Q_W    = PROD_W + 1 - FRAC;

    logic signed [D_W-1:0]    diff;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W:0]   rounded;
    logic        [Q_W-1:0]    q;
    logic                     ovf;

    // Sixteen times the median minus the center, then the exact product.
    always_comb begin
        diff   = $signed({{2{i_med[RAW_W-1]}}, i_med, 4'b0000})
               - $signed({{(D_W-CEN_W){i_center[CEN_W-1]}}, i_center});
        gain_s = $signed({1'b0, i_gain});
        n_prod = diff * gain_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // Round half up at bit 14 and saturate to the Q3.14 range.
    always_comb begin
        rounded = $signed({r_prod[PROD_W-1], r_prod})
                + $signed((PROD_W+1)'(1 << (FRAC - 1)));
        q       = rounded[PROD_W:FRAC];
        ovf     = (q[Q_W-1:NORM_W-1] != {(Q_W-NORM_W+1){1'b0}})
               && (q[Q_W-1:NORM_W-1] != {(Q_W-NORM_W+1){1'b1}});
        o_res.clip = ovf;
        if (!ovf) begin
            o_res.norm = q[NORM_W-1:0];
        end else if (q[Q_W-1]) begin
            o_res.norm = {1'b1, {(NORM_W-1){1'b0}}};
        end else begin
            o_res.norm = {1'b0, {(NORM_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/core/magnetometer_median_normalizer.sv =====
// Magnetometer median normalizer. A changed reading is ranked on the x window, then on
// the y window; r_x and r_y are the 1..WINDOW_LEN rank steps of each axis. Each median
// passes the multiply and round states, and the output state loads the output register.
// No new reading is taken until the block is back in idle, and o_stall is high until then.
// A waiting result on a stalled output holds the block in the output state. An unchanged
// reading is taken and gives nothing. Synchronous active-low reset clears the windows
// and the last reading, and returns the configuration to its defaults.
module magnetometer_median_normalizer #(
    parameter int WINDOW_LEN = mmn_pkg::MMN_WINDOW_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input reading channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mmn_pkg::RAW_W-1:0]       i_raw_x,
    input  logic [mmn_pkg::RAW_W-1:0]       i_raw_y,
    input  logic [mmn_pkg::RAW_W-1:0]       i_raw_z,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mmn_pkg::NORM_W-1:0]      o_norm_x,
    output logic [mmn_pkg::NORM_W-1:0]      o_norm_y,
    output logic                            o_clipped,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mmn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mmn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mmn_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_MUL,
        S_RND,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_axis;
    logic [IDX_W-1:0] r_idx;
    logic [RAW_W-1:0] r_med;
    logic [NORM_W-1:0] r_nx;
    logic [NORM_W-1:0] r_ny;
    logic r_clip;
    logic r_out_valid;
    logic [NORM_W-1:0] r_out_x;
    logic [NORM_W-1:0] r_out_y;
    logic r_out_clip;

    logic [WINDOW_LEN-1:0][RAW_W-1:0] r_win_x;
    logic [WINDOW_LEN-1:0][RAW_W-1:0] r_win_y;
    logic [RAW_W-1:0] r_last_x;
    logic [RAW_W-1:0] r_last_y;
    logic [RAW_W-1:0] r_last_z;

    logic [CEN_W-1:0]  r_center_x;
    logic [CEN_W-1:0]  r_center_y;
    logic [GAIN_W-1:0] r_gain;

    logic in_accept;
    logic changed;
    logic out_free;
    logic [WINDOW_LEN-1:0][RAW_W-1:0] rank_win;
    logic [RAW_W-1:0] rank_cand;
    logic rank_hit;
    t_scale_res scale_res;

    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && !o_stall;
    assign changed     = (i_raw_x != r_last_x) || (i_raw_y != r_last_y)
                      || (i_raw_z != r_last_z);
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid   = r_out_valid;
    assign o_norm_x  = r_out_x;
    assign o_norm_y  = r_out_y;
    assign o_clipped = r_out_clip;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_gain     <= RANGE_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CENTER_X) begin
                r_center_x <= i_cfg_data[CEN_W-1:0];
            end else if (i_cfg_index == CFG_CENTER_Y) begin
                r_center_y <= i_cfg_data[CEN_W-1:0];
            end else if (i_cfg_index == CFG_RANGE_GAIN) begin
                r_gain <= i_cfg_data[GAIN_W-1:0];
            end
        end
    end

    // Rank search runs over the x window first, then the y window.
    assign rank_win = r_axis ? r_win_y : r_win_x;

    mmn_rank #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_rank (
        .i_win  (rank_win),
        .i_idx  (r_idx),
        .o_cand (rank_cand),
        .o_hit  (rank_hit)
    );

    mmn_scale u_scale (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MUL),
        .i_med    (r_med),
        .i_center (r_axis ? r_center_y : r_center_x),
        .i_gain   (r_gain),
        .o_res    (scale_res)
    );

    // Sequencer, window storage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_idx       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_x     <= '0;
            r_win_y     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_z    <= '0;
        end else begin
            // The output state reloads the register itself when it is taken.
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && changed) begin
                        r_last_x <= i_raw_x;
                        r_last_y <= i_raw_y;
                        r_last_z <= i_raw_z;
                        r_win_x  <= {r_win_x[WINDOW_LEN-2:0], i_raw_x};
                        r_win_y  <= {r_win_y[WINDOW_LEN-2:0], i_raw_y};
                        r_axis   <= 1'b0;
                        r_idx    <= '0;
                        r_clip   <= 1'b0;
                        r_state  <= S_RANK;
                    end
                end
                S_RANK: begin
                    if (rank_hit) begin
                        r_med   <= rank_cand;
                        r_state <= S_MUL;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_clip <= r_clip | scale_res.clip;
                    if (!r_axis) begin
                        r_nx    <= scale_res.norm;
                        r_axis  <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_RANK;
                    end else begin
                        r_ny    <= scale_res.norm;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_nx;
                        r_out_y     <= r_ny;
                        r_out_clip  <= r_clip;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The rank search always finds the median by the last tap.
    a_rank_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK && r_idx == IDX_W'(WINDOW_LEN - 1)) |-> rank_hit)
        else $error("median not found in window");

    // A result only appears out of the output state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output state");

    // A changed reading starts the rank search on the x window.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && changed) |=> (r_state == S_RANK && !r_axis))
        else $error("changed reading did not start processing");
`endif

endmodule
